@@ design/blkc_pkg.sv @@
package blkc_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int IN_W            = 56;
    localparam int OUT_W           = 56;
    localparam int SLOT_W          = 4;
    localparam int DEV_W           = 16;
    localparam int BLK_W           = 32;
    localparam int ENT_W           = 4;
    localparam int REF_W           = 8;
    localparam int WBC_W           = 5;
    localparam logic [WBC_W-1:0] WB_MAX = 5'd16;

    typedef enum logic [1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_MARK    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_SYNC    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_HIT   = 3'd0,
        ST_FILL  = 3'd1,
        ST_WAIT  = 3'd2,
        ST_NOBUF = 3'd3,
        ST_WB    = 3'd4,
        ST_DONE  = 3'd5,
        ST_ERR   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HSCAN,
        S_VSCAN,
        S_FILL,
        S_MARK,
        S_REL,
        S_PSCAN,
        S_SSCAN,
        S_SDONE
    } state_t;

    typedef enum logic [1:0] {
        SEL_ORDER,
        SEL_K,
        SEL_ENT
    } sel_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_REQ,
        SRC_CUR
    } src_t;

    typedef struct packed {
        logic    load;
        logic    k_top;
        logic    k_zero;
        logic    k_inc;
        logic    k_dec;
        logic    wbc_clr;
        logic    wbc_inc;
        sel_t    sel;
        logic    emit;
        status_t st;
        src_t    src;
        logic    last;
        logic    do_hit;
        logic    do_claim;
        logic    do_clr_dirty;
        logic    do_mark;
        logic    do_rel;
        logic    do_shift;
    } cmd_t;

    typedef struct packed {
        action_t in_action;
        logic    match;
        logic    locked;
        logic    free;
        logic    dirty;
        logic    k_first;
        logic    k_last;
        logic    wb_room;
        logic    rel_one;
        logic    ref_zero;
        logic    pos_match;
        logic    ent_ok;
        logic    out_free;
    } sts_t;

endpackage

@@ design/blkc_datapath.sv @@
module blkc_datapath #(
    parameter int NUM_ENTRIES = blkc_pkg::NUM_ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [blkc_pkg::IN_W-1:0]  s_tdata,
    output logic [blkc_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  blkc_pkg::cmd_t            cmd,
    output blkc_pkg::sts_t            sts
);
    import blkc_pkg::*;

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam logic [IW-1:0] K_TOP = IW'(NUM_ENTRIES - 1);

    logic [DEV_W-1:0] dev_reg;
    logic [BLK_W-1:0] blk_reg;
    logic [ENT_W-1:0] ent_reg;
    logic [IW-1:0]    k_reg;
    logic [WBC_W-1:0] wbc_reg;

    logic [DEV_W-1:0] tag_dev_reg [NUM_ENTRIES];
    logic [BLK_W-1:0] tag_blk_reg [NUM_ENTRIES];
    logic             lock_reg    [NUM_ENTRIES];
    logic             dirty_reg   [NUM_ENTRIES];
    logic [REF_W-1:0] ref_reg     [NUM_ENTRIES];
    logic [IW-1:0]    order_reg   [NUM_ENTRIES];

    logic [2:0]       ost_reg;
    logic [SLOT_W-1:0] oslot_reg;
    logic [DEV_W-1:0] odev_reg;
    logic [BLK_W-1:0] oblk_reg;
    logic             olast_reg;
    logic             ovalid_reg;

    logic             ent_ok;
    logic [IW-1:0]    ent_idx;
    logic [IW-1:0]    cur;

    assign ent_ok  = {2'b00, ent_reg} < 6'(NUM_ENTRIES);
    assign ent_idx = ent_ok ? IW'(ent_reg) : '0;

    always_comb
    begin
        unique case (cmd.sel)
            SEL_ORDER: cur = order_reg[k_reg];
            SEL_K:     cur = k_reg;
            SEL_ENT:   cur = ent_idx;
            default:   cur = k_reg;
        endcase
    end

    always_comb
    begin
        sts.in_action = action_t'(s_tdata[1:0]);
        sts.match     = (tag_dev_reg[cur] == dev_reg) && (tag_blk_reg[cur] == blk_reg);
        sts.locked    = lock_reg[cur];
        sts.free      = !lock_reg[cur] && (ref_reg[cur] == '0);
        sts.dirty     = dirty_reg[cur];
        sts.k_first   = (k_reg == '0);
        sts.k_last    = (k_reg == K_TOP);
        sts.wb_room   = (wbc_reg < WB_MAX);
        sts.rel_one   = (ref_reg[cur] == REF_W'(1));
        sts.ref_zero  = (ref_reg[cur] == '0);
        sts.pos_match = (order_reg[k_reg] == ent_idx);
        sts.ent_ok    = ent_ok;
        sts.out_free  = !ovalid_reg || m_tready;
    end

    // capture request fields (the scan index steps in the block below)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dev_reg <= s_tdata[17:2];
            blk_reg <= s_tdata[49:18];
            ent_reg <= s_tdata[53:50];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= '0;
            wbc_reg <= '0;
        end
        else
        begin
            if (cmd.k_top)
                k_reg <= K_TOP;
            else if (cmd.k_zero)
                k_reg <= '0;
            else if (cmd.k_inc)
                k_reg <= k_reg + IW'(1);
            else if (cmd.k_dec)
                k_reg <= k_reg - IW'(1);
            if (cmd.wbc_clr)
                wbc_reg <= '0;
            else if (cmd.wbc_inc)
                wbc_reg <= wbc_reg + WBC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                tag_dev_reg[i] <= '0;
                tag_blk_reg[i] <= '0;
                lock_reg[i]    <= 1'b0;
                dirty_reg[i]   <= 1'b0;
                ref_reg[i]     <= '0;
                order_reg[i]   <= IW'(i);
            end
        end
        else
        begin
            if (cmd.do_hit)
            begin
                lock_reg[cur] <= 1'b1;
                if (ref_reg[cur] != '1)
                    ref_reg[cur] <= ref_reg[cur] + REF_W'(1);
            end
            if (cmd.do_clr_dirty)
                dirty_reg[cur] <= 1'b0;
            if (cmd.do_claim)
            begin
                tag_dev_reg[cur] <= dev_reg;
                tag_blk_reg[cur] <= blk_reg;
                lock_reg[cur]    <= 1'b1;
                dirty_reg[cur]   <= 1'b0;
                ref_reg[cur]     <= REF_W'(1);
            end
            if (cmd.do_mark)
                dirty_reg[cur] <= 1'b1;
            if (cmd.do_rel)
            begin
                lock_reg[cur] <= 1'b0;
                ref_reg[cur]  <= ref_reg[cur] - REF_W'(1);
            end
            // move the released entry to the newest end of the age list
            if (cmd.do_shift)
            begin
                for (int j = 0; j < NUM_ENTRIES - 1; j++)
                begin
                    if (IW'(j) >= k_reg)
                        order_reg[j] <= order_reg[j + 1];
                end
                order_reg[NUM_ENTRIES - 1] <= ent_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.emit)
            ovalid_reg <= 1'b1;
        else if (m_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ost_reg   <= cmd.st;
            olast_reg <= cmd.last;
            unique case (cmd.src)
                SRC_REQ:
                begin
                    oslot_reg <= SLOT_W'(cur);
                    odev_reg  <= dev_reg;
                    oblk_reg  <= blk_reg;
                end
                SRC_CUR:
                begin
                    oslot_reg <= SLOT_W'(cur);
                    odev_reg  <= tag_dev_reg[cur];
                    oblk_reg  <= tag_blk_reg[cur];
                end
                default:
                begin
                    oslot_reg <= '0;
                    odev_reg  <= '0;
                    oblk_reg  <= '0;
                end
            endcase
        end
    end

    assign m_tdata  = {1'b0, oblk_reg, odev_reg, oslot_reg, ost_reg};
    assign m_tlast  = olast_reg;
    assign m_tvalid = ovalid_reg;

endmodule

@@ design/blkc_ctrl.sv @@
module blkc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  blkc_pkg::sts_t sts,
    output blkc_pkg::cmd_t cmd
);
    import blkc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (sts.in_action)
                        ACT_ACQUIRE: state_next = S_HSCAN;
                        ACT_MARK:    state_next = S_MARK;
                        ACT_RELEASE: state_next = S_REL;
                        default:     state_next = S_SSCAN;
                    endcase
                end
            end
            S_HSCAN:
            begin
                if (sts.match)
                begin
                    if (sts.out_free)
                        state_next = S_IDLE;
                end
                else if (sts.k_first)
                    state_next = S_VSCAN;
            end
            S_VSCAN:
            begin
                if (sts.free)
                begin
                    if (sts.out_free)
                        state_next = sts.dirty ? S_FILL : S_IDLE;
                end
                else if (sts.k_last && sts.out_free)
                    state_next = S_IDLE;
            end
            S_FILL, S_MARK, S_SDONE:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            S_REL:
            begin
                if (sts.out_free)
                    state_next = (sts.ent_ok && !sts.ref_zero && sts.rel_one) ? S_PSCAN
                                                                              : S_IDLE;
            end
            S_PSCAN:
            begin
                if (sts.pos_match)
                    state_next = S_IDLE;
            end
            S_SSCAN:
            begin
                if (!(sts.dirty && sts.wb_room && !sts.out_free) && sts.k_last)
                    state_next = S_SDONE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.sel  = SEL_ORDER;
        cmd.st   = ST_DONE;
        cmd.src  = SRC_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load    = 1'b1;
                    cmd.k_top   = (sts.in_action == ACT_ACQUIRE);
                    cmd.k_zero  = (sts.in_action == ACT_SYNC);
                    cmd.wbc_clr = (sts.in_action == ACT_SYNC);
                end
            end
            S_HSCAN:
            begin
                if (sts.match)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.st     = sts.locked ? ST_WAIT : ST_HIT;
                        cmd.src    = SRC_REQ;
                        cmd.last   = 1'b1;
                        cmd.do_hit = !sts.locked;
                    end
                end
                else if (sts.k_first)
                    cmd.k_zero = 1'b1;
                else
                    cmd.k_dec = 1'b1;
            end
            S_VSCAN:
            begin
                if (sts.free)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit = 1'b1;
                        if (sts.dirty)
                        begin
                            // write back the old tag before the fill
                            cmd.st           = ST_WB;
                            cmd.src          = SRC_CUR;
                            cmd.do_clr_dirty = 1'b1;
                        end
                        else
                        begin
                            cmd.st       = ST_FILL;
                            cmd.src      = SRC_REQ;
                            cmd.last     = 1'b1;
                            cmd.do_claim = 1'b1;
                        end
                    end
                end
                else if (sts.k_last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit = 1'b1;
                        cmd.st   = ST_NOBUF;
                        cmd.last = 1'b1;
                    end
                end
                else
                    cmd.k_inc = 1'b1;
            end
            S_FILL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.st       = ST_FILL;
                    cmd.src      = SRC_REQ;
                    cmd.last     = 1'b1;
                    cmd.do_claim = 1'b1;
                end
            end
            S_MARK:
            begin
                cmd.sel = SEL_ENT;
                if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.last    = 1'b1;
                    cmd.st      = (sts.ent_ok && sts.locked) ? ST_DONE : ST_ERR;
                    cmd.do_mark = sts.ent_ok && sts.locked;
                end
            end
            S_REL:
            begin
                cmd.sel = SEL_ENT;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.st     = (sts.ent_ok && !sts.ref_zero) ? ST_DONE : ST_ERR;
                    cmd.do_rel = sts.ent_ok && !sts.ref_zero;
                    cmd.k_zero = 1'b1;
                end
            end
            S_PSCAN:
            begin
                if (sts.pos_match)
                    cmd.do_shift = 1'b1;
                else
                    cmd.k_inc = 1'b1;
            end
            S_SSCAN:
            begin
                cmd.sel = SEL_K;
                if (sts.dirty && sts.wb_room)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.st      = ST_WB;
                        cmd.src     = SRC_CUR;
                        cmd.wbc_inc = 1'b1;
                        cmd.k_inc   = !sts.k_last;
                    end
                end
                else
                    cmd.k_inc = !sts.k_last;
            end
            S_SDONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ design/block_buffer_cache_lru.sv @@
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: action, dev, block, entry
// m_       out  m_tvalid/m_tready  m_tdata: status, slot, out_dev, out_block; m_tlast: last
//
// One request at a time, stepped by one entry per cycle unless the output stalls.
// Acquire: newest-first tag scan, then victim scan, both over the age list.
// Release to count zero adds a scan of the age list to find the entry's age slot.
// Sync: writes back up to WB_MAX dirty entries in index order, then gives a final result.
// Reset clears tags, flags and counts and sets the age list to index order.
// A full output register stalls the sequencer when it has a result to emit; a new request
// is taken while the final result still waits.
module block_buffer_cache_lru #(
    parameter int NUM_ENTRIES = blkc_pkg::NUM_ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [1:0] action, [17:2] dev, [49:18] block, [53:50] entry
    input  logic [blkc_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [2:0] status, [6:3] slot, [22:7] out_dev, [54:23] out_block
    output logic [blkc_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tlast
);
    import blkc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    blkc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    blkc_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == ST_WB) |-> !m_tlast)
        else $error("writeback marked last");

    a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != ST_WB) |-> m_tlast)
        else $error("final result not marked last");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tdata[2:0] == ST_DONE) || (m_tdata[2:0] == ST_ERR)
                     || (m_tdata[2:0] == ST_NOBUF)) |-> (m_tdata[54:3] == '0))
        else $error("nonzero fields on status-only result");

endmodule

@@ verif/cache_checker.sv @@
module cache_checker
    import blkc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             m_tlast,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = NUM_ENTRIES_DEF;

    typedef struct packed {
        status_t          status;
        logic [SLOT_W-1:0] slot;
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic              last;
    } cache_resp_t;

    cache_resp_t       resp_q[$];
    logic [DEV_W-1:0]  c_dev[N];
    logic [BLK_W-1:0]  c_blk[N];
    logic              c_lock[N];
    logic              c_dirty[N];
    logic [REF_W-1:0]  c_cnt[N];
    int                age[N];

    assign pending = resp_q.size();

    function automatic cache_resp_t mk(status_t s, int e, logic [DEV_W-1:0] d,
                                       logic [BLK_W-1:0] b, logic l);
        cache_resp_t r;
        r.status = s;
        r.slot = SLOT_W'(e);
        r.dev = d;
        r.blk = b;
        r.last = l;
        return r;
    endfunction

    task automatic bump_newest(int e);
        int p;
        p = 0;
        for (int k = 0; k < N; k++)
            if (age[k] == e) p = k;
        for (int k = p; k + 1 < N; k++) age[k] = age[k+1];
        age[N-1] = e;
    endtask

    task automatic predict_request(logic [IN_W-1:0] d);
        action_t          act;
        logic [DEV_W-1:0] dv;
        logic [BLK_W-1:0] bl;
        int               ent;
        int               e;
        bit               found;
        act = action_t'(d[1:0]);
        dv = d[17:2];
        bl = d[49:18];
        ent = int'(d[53:50]);
        found = 0;
        case (act)
            ACT_ACQUIRE:
            begin
                for (int k = N - 1; k >= 0 && !found; k--)
                begin
                    e = age[k];
                    if (c_dev[e] == dv && c_blk[e] == bl)
                    begin
                        found = 1;
                        if (c_lock[e])
                            resp_q.push_back(mk(ST_WAIT, e, dv, bl, 1));
                        else
                        begin
                            c_lock[e] = 1;
                            if (c_cnt[e] != 8'hFF) c_cnt[e]++;
                            resp_q.push_back(mk(ST_HIT, e, dv, bl, 1));
                        end
                    end
                end
                for (int k = 0; k < N && !found; k++)
                begin
                    e = age[k];
                    if (!c_lock[e] && c_cnt[e] == 0)
                    begin
                        found = 1;
                        if (c_dirty[e])
                            resp_q.push_back(mk(ST_WB, e, c_dev[e], c_blk[e], 0));
                        c_cnt[e] = 1;
                        c_lock[e] = 1;
                        c_dirty[e] = 0;
                        c_dev[e] = dv;
                        c_blk[e] = bl;
                        resp_q.push_back(mk(ST_FILL, e, dv, bl, 1));
                    end
                end
                if (!found) resp_q.push_back(mk(ST_NOBUF, 0, 0, 0, 1));
            end
            ACT_MARK:
            begin
                if (ent >= N || !c_lock[ent])
                    resp_q.push_back(mk(ST_ERR, 0, 0, 0, 1));
                else
                begin
                    c_dirty[ent] = 1;
                    resp_q.push_back(mk(ST_DONE, 0, 0, 0, 1));
                end
            end
            ACT_RELEASE:
            begin
                if (ent >= N || c_cnt[ent] == 0)
                    resp_q.push_back(mk(ST_ERR, 0, 0, 0, 1));
                else
                begin
                    c_cnt[ent]--;
                    if (c_cnt[ent] == 0) bump_newest(ent);
                    c_lock[ent] = 0;
                    resp_q.push_back(mk(ST_DONE, 0, 0, 0, 1));
                end
            end
            default:
            begin
                for (int k = 0; k < N; k++)
                    if (c_dirty[k])
                        resp_q.push_back(mk(ST_WB, k, c_dev[k], c_blk[k], 0));
                resp_q.push_back(mk(ST_DONE, 0, 0, 0, 1));
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cache_resp_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            resp_q.delete();
            for (int k = 0; k < N; k++)
            begin
                c_dev[k] = '0;
                c_blk[k] = '0;
                c_lock[k] = 0;
                c_dirty[k] = 0;
                c_cnt[k] = '0;
                age[k] = k;
            end
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (resp_q.size() == 0)
                begin
                    $error("unexpected result %h last %b", m_tdata, m_tlast);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = resp_q.pop_front();
                    if (m_tdata[2:0] != want.status ||
                        m_tdata[6:3] != want.slot ||
                        m_tdata[22:7] != want.dev ||
                        m_tdata[54:23] != want.blk ||
                        m_tlast != want.last)
                        fail_count <= fail_count + 1;
                    if (m_tdata[2:0] != want.status)
                        $error("status expected %0d actual %0d", want.status, m_tdata[2:0]);
                    if (m_tdata[6:3] != want.slot)
                        $error("slot expected %0d actual %0d", want.slot, m_tdata[6:3]);
                    if (m_tdata[22:7] != want.dev)
                        $error("out_dev expected %h actual %h", want.dev, m_tdata[22:7]);
                    if (m_tdata[54:23] != want.blk)
                        $error("out_block expected %h actual %h", want.blk, m_tdata[54:23]);
                    if (m_tlast != want.last)
                        $error("last expected %b actual %b", want.last, m_tlast);
                end
            end
            // predict after popping so a same-cycle result is matched first
            if (s_tvalid && s_tready) predict_request(s_tdata);
        end
    end
endmodule

@@ verif/tb.sv @@
module tb;
    import blkc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic             clk = 0;
    logic             rst_n = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    int               fail_count;
    int               pending;
    int               idle_cycles = 0;
    bit               hold_off = 0;

    always #5 clk = ~clk;

    block_buffer_cache_lru u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    cache_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic logic [IN_W-1:0] pack_req(action_t a, logic [DEV_W-1:0] d,
                                                 logic [BLK_W-1:0] b, logic [ENT_W-1:0] e);
        return {2'b00, e, b, d, a};
    endfunction

    // small tag pool keeps hits, waits and victims frequent
    function automatic logic [IN_W-1:0] rand_req();
        logic [DEV_W-1:0] d;
        logic [BLK_W-1:0] b;
        int               r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return {2'b00, 54'($urandom()) ^ {22'($urandom()), 32'($urandom())}};
        d = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2));
        b = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 20));
        if (r < 50) return pack_req(ACT_ACQUIRE, d, b, 4'($urandom()));
        if (r < 65) return pack_req(ACT_MARK, 16'($urandom()), $urandom(), 4'($urandom()));
        if (r < 94) return pack_req(ACT_RELEASE, 16'($urandom()), $urandom(), 4'($urandom()));
        return pack_req(ACT_SYNC, 16'($urandom()), $urandom(), 4'($urandom()));
    endfunction

    task automatic send_req(logic [IN_W-1:0] d);
        s_tdata <= d;
        s_tvalid <= 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic gap();
        s_tvalid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
    endtask

    // receiver stall pattern, with one long hold-off
    always @(posedge clk)
    begin
        if (hold_off) m_tready <= 0;
        else if ($urandom_range(0, 3) == 0) m_tready <= ~m_tready;
        else m_tready <= ($urandom_range(0, 4) != 0);
    end

    initial
    begin
        hold_off = 1;
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_off = 0;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("FAIL block_buffer_cache_lru");
            $finish;
        end
    end

    initial
    begin
        int burst;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // initial tags hit, then locked wait, dirty marks, releases, errors
        send_req(pack_req(ACT_ACQUIRE, 16'h0, 32'h0, 4'h0));
        send_req(pack_req(ACT_ACQUIRE, 16'h0, 32'h0, 4'hF));
        send_req(pack_req(ACT_MARK, 16'hFFFF, 32'hFFFFFFFF, 4'hF));
        send_req(pack_req(ACT_MARK, 16'h0, 32'h0, 4'h0));
        send_req(pack_req(ACT_RELEASE, 16'h0, 32'h0, 4'h0));
        send_req(pack_req(ACT_RELEASE, 16'h0, 32'h0, 4'hF));
        send_req(pack_req(ACT_RELEASE, 16'h0, 32'h0, 4'hF));
        send_req(pack_req(ACT_ACQUIRE, 16'hFFFF, 32'hFFFFFFFF, 4'h0));
        send_req(pack_req(ACT_MARK, 16'h0, 32'h0, 4'h0));
        send_req(pack_req(ACT_SYNC, 16'h0, 32'h0, 4'h0));
        // fill every entry to reach no buffer and dirty victims
        for (int i = 1; i <= 16; i++)
            send_req(pack_req(ACT_ACQUIRE, 16'h1, 32'(i), 4'h0));
        for (int i = 0; i < 16; i++)
            send_req(pack_req(ACT_RELEASE, 16'h0, 32'h0, 4'(i)));
        send_req(pack_req(ACT_SYNC, 16'h0, 32'h0, 4'h0));
        send_req(pack_req(ACT_ACQUIRE, 16'h2, 32'h5, 4'h0));
        // pause until everything has drained
        s_tvalid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        for (int n = 0; n < 106; n += burst)
        begin
            burst = $urandom_range(1, 10);
            for (int j = 0; j < burst; j++) send_req(rand_req());
            if ($urandom_range(0, 2) != 0) gap();
        end
        s_tvalid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS block_buffer_cache_lru");
        else
            $display("FAIL block_buffer_cache_lru");
        $finish;
    end
endmodule
